// ===== hw/rtl/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types and constants of the clamped PID controller: command and
// register codes, and the control/status bundle of the shared mul/div unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pid_pkg;

    // default datapath shape, signed Q16.16
    parameter int DATA_WIDTH_DEF = 32;
    parameter int FRAC_BITS_DEF  = 16;

    // configuration register index width (eight registers)
    parameter int CFG_IDX_W = 3;

    // item commands
    typedef enum logic [1:0] {
        CMD_SETPOINT = 2'd0,
        CMD_ERROR    = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_STEP_TIME = 3'd3,
        REG_DRIVE_MIN = 3'd4,
        REG_DRIVE_MAX = 3'd5,
        REG_ACCUM_MIN = 3'd6,
        REG_ACCUM_MAX = 3'd7
    } t_cfg_idx;

    // operations of the shared unit
    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_mdu_op;

    // sequencer to unit
    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_ctrl;

    // unit to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_stat;

endpackage

// ===== hw/rtl/pid_in_if.sv =====
// ----------------------------------------------------------------------------
// pid_in_if
// Input item channel: command and operands with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pid_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   cmd;
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [DATA_WIDTH-1:0] measured;
    logic signed [DATA_WIDTH-1:0] err_in;

    modport source (output valid, cmd, target, measured, err_in, input ready);
    modport sink   (input valid, cmd, target, measured, err_in, output ready);
endinterface

// ===== hw/rtl/pid_out_if.sv =====
// ----------------------------------------------------------------------------
// pid_out_if
// Result item channel: controller drive and disabled flag, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pid_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         disabled;

    modport source (output valid, drive, disabled, input ready);
    modport sink   (input valid, drive, disabled, output ready);
endinterface

// ===== hw/rtl/pid_mdu.sv =====
// ----------------------------------------------------------------------------
// pid_mdu
// Shared fixed-point multiply / divide unit. One add/subtract per cycle:
// shift-add multiply (a*b >> FRAC_BITS) and restoring
// divide ((a << FRAC_BITS) / b, b > 0).
// Results truncate toward zero and saturate to DATA_WIDTH bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_mdu import pid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_mdu_ctrl                    i_ctrl,
    input  logic signed [DATA_WIDTH-1:0] i_opa,
    input  logic signed [DATA_WIDTH-1:0] i_opb,
    output t_mdu_stat                    o_stat,
    output logic signed [DATA_WIDTH-1:0] o_result
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int LW = W + F;
    localparam int CW = $clog2(LW + 1);

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_FIN
    } t_ustate;

    t_ustate         r_state;
    t_mdu_op         r_op;
    logic            r_neg;
    logic [W-1:0]    r_x;
    logic [W-1:0]    r_hi;
    logic [LW-1:0]   r_lo;
    logic [CW-1:0]   r_cnt;
    logic [W-1:0]    r_res;
    logic            r_done;

    // magnitude of a signed word; the most negative value fits unsigned
    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        return a[W-1] ? (~a + W'(1)) : a;
    endfunction

    // shared adder: accumulate for multiply, trial subtract for divide
    logic          sub;
    logic [W:0]    rem_sh;
    logic [W:0]    add_a;
    logic [W:0]    add_x;
    logic [W+1:0]  add_y;
    logic          carry;

    assign sub    = (r_op == OP_DIV);
    assign rem_sh = {r_hi, r_lo[LW-1]};
    assign add_a  = sub ? rem_sh : {1'b0, r_hi};
    assign add_x  = (sub || r_lo[0]) ? {1'b0, r_x} : '0;
    assign add_y  = {1'b0, add_a} + {1'b0, add_x ^ {(W+1){sub}}} + (W+2)'(sub);
    assign carry  = add_y[W+1];

    // final scaling, saturation and sign
    logic [2*W-1:0] prod;
    logic [2*W-1:0] prod_q;
    logic           fin_ovf;
    logic [W-2:0]   fin_low;
    logic [W-1:0]   fin_mag;
    logic [W-1:0]   n_res;

    always_comb begin
        prod   = {r_hi, r_lo[W-1:0]};
        prod_q = prod >> F;
        if (r_op == OP_DIV) begin
            fin_ovf = |r_lo[LW-1:W-1];
            fin_low = r_lo[W-2:0];
        end else begin
            fin_ovf = |prod_q[2*W-1:W-1];
            fin_low = prod_q[W-2:0];
        end
        fin_mag = {1'b0, fin_low};
        if (fin_ovf) begin
            n_res = r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            n_res = r_neg ? (~fin_mag + W'(1)) : fin_mag;
        end
    end

    // sequencer of the unit and its datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_ctrl.start) begin
                        r_op  <= i_ctrl.op;
                        r_hi  <= '0;
                        if (i_ctrl.op == OP_DIV) begin
                            r_x   <= mag(i_opb);
                            r_lo  <= LW'(mag(i_opa)) << F;
                            r_neg <= i_opa[W-1];
                            r_cnt <= CW'(LW);
                        end else begin
                            r_x   <= mag(i_opa);
                            r_lo  <= LW'(mag(i_opb));
                            r_neg <= i_opa[W-1] ^ i_opb[W-1];
                            r_cnt <= CW'(W);
                        end
                        r_state <= U_RUN;
                    end
                end
                U_RUN: begin
                    if (r_op == OP_DIV) begin
                        r_hi <= carry ? add_y[W-1:0] : rem_sh[W-1:0];
                        r_lo <= {r_lo[LW-2:0], carry};
                    end else begin
                        r_hi <= add_y[W:1];
                        r_lo <= LW'({add_y[0], r_lo[W-1:1]});
                    end
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    r_res   <= n_res;
                    r_done  <= 1'b1;
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != U_IDLE);
    assign o_stat.done = r_done;
    assign o_result    = r_res;

endmodule

// ===== hw/rtl/pid_controller_clamped.sv =====
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Discrete PID step in signed fixed point with integral clamp and output
// limits. A small sequencer runs every product and the derivative quotient
// through one shared bit-serial mul/div unit.
//
//  channel   dir  handshake        payload
//  i_item    in   valid / ready    cmd, target, measured, err_in
//  o_result  out  valid / ready    drive, disabled
//  cfg       in   i_cfg_we         i_cfg_idx, i_cfg_data (no read-back)
//
//  An update runs its products and the derivative quotient in turn through
//  the one-bit-per-cycle adder in pid_mdu (signed Q16.16 by default); the
//  first update after a clear skips the divide and derivative product.
//  Clear, unused and disabled items bypass the unit. One item at a time.
//  Reset is synchronous and restores registers and controller state.
//  A waiting result does not block the next item until its own result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_controller_clamped import pid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pid_in_if.sink                i_item,
    pid_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_MDT,
        S_DIV,
        S_MP,
        S_MI,
        S_MD,
        S_CLAMP,
        S_DONE
    } t_state;

    // saturating arithmetic on W-bit words
    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? SMIN : SMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? SMIN : SMAX;
        end
        return s[W-1:0];
    endfunction

    // below lo gives lo, otherwise above hi gives hi
    function automatic logic [W-1:0] clamp(input logic signed [W-1:0] v,
                                           input logic signed [W-1:0] lo,
                                           input logic signed [W-1:0] hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    t_state               r_state;
    logic                 r_go;
    logic signed [W-1:0]  r_gain_p;
    logic signed [W-1:0]  r_gain_i;
    logic signed [W-1:0]  r_gain_d;
    logic signed [W-1:0]  r_step;
    logic signed [W-1:0]  r_drive_min;
    logic signed [W-1:0]  r_drive_max;
    logic signed [W-1:0]  r_accum_min;
    logic signed [W-1:0]  r_accum_max;
    logic signed [W-1:0]  r_acc;
    logic signed [W-1:0]  r_last;
    logic                 r_first;
    logic signed [W-1:0]  r_err;
    logic signed [W-1:0]  r_diff;
    logic signed [W-1:0]  r_der;
    logic signed [W-1:0]  r_sum;
    logic                 r_dis;
    logic                 r_out_valid;
    logic signed [W-1:0]  r_out_drive;
    logic                 r_out_dis;

    t_mdu_ctrl            mdu_ctrl;
    t_mdu_stat            mdu_stat;
    logic signed [W-1:0]  mdu_a;
    logic signed [W-1:0]  mdu_b;
    logic signed [W-1:0]  mdu_res;

    logic                 in_fire;
    logic                 out_slot;
    logic                 step_off;
    logic [W-1:0]         n_err;
    logic [W-1:0]         n_acc;
    logic [W-1:0]         n_sum;

    assign in_fire  = i_item.valid && i_item.ready;
    assign out_slot = !r_out_valid || o_result.ready;
    assign step_off = r_step[W-1] || (r_step == '0);
    assign n_err    = (t_cmd'(i_item.cmd) == CMD_SETPOINT)
                    ? sat_sub(i_item.target, i_item.measured) : i_item.err_in;
    assign n_acc    = clamp(sat_add(r_acc, mdu_res), r_accum_min, r_accum_max);
    assign n_sum    = sat_add(r_sum, mdu_res);

    // operand selection for the shared unit
    always_comb begin
        mdu_ctrl.start = r_go;
        mdu_ctrl.op    = OP_MUL;
        mdu_a          = r_err;
        mdu_b          = r_step;
        unique case (r_state)
            S_MDT: begin
                mdu_a = r_err;
                mdu_b = r_step;
            end
            S_DIV: begin
                mdu_ctrl.op = OP_DIV;
                mdu_a       = r_diff;
                mdu_b       = r_step;
            end
            S_MP: begin
                mdu_a = r_gain_p;
                mdu_b = r_err;
            end
            S_MI: begin
                mdu_a = r_gain_i;
                mdu_b = r_acc;
            end
            S_MD: begin
                mdu_a = r_gain_d;
                mdu_b = r_der;
            end
            default: begin
                mdu_a = r_err;
                mdu_b = r_step;
            end
        endcase
    end

    pid_mdu #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mdu_ctrl),
        .i_opa    (mdu_a),
        .i_opb    (mdu_b),
        .o_stat   (mdu_stat),
        .o_result (mdu_res)
    );

    // sequencer, controller state, registers and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_step      <= W'(1) << FRAC_BITS;
            r_drive_min <= SMIN;
            r_drive_max <= SMAX;
            r_accum_min <= SMIN;
            r_accum_max <= SMAX;
            r_acc       <= '0;
            r_last      <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;

            // configuration writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    REG_GAIN_P:    r_gain_p    <= i_cfg_data;
                    REG_GAIN_I:    r_gain_i    <= i_cfg_data;
                    REG_GAIN_D:    r_gain_d    <= i_cfg_data;
                    REG_STEP_TIME: r_step      <= i_cfg_data;
                    REG_DRIVE_MIN: r_drive_min <= i_cfg_data;
                    REG_DRIVE_MAX: r_drive_max <= i_cfg_data;
                    REG_ACCUM_MIN: r_accum_min <= i_cfg_data;
                    REG_ACCUM_MAX: r_accum_max <= i_cfg_data;
                    default: ;
                endcase
            end

            // result taken downstream
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_sum <= '0;
                        r_dis <= 1'b0;
                        unique case (t_cmd'(i_item.cmd))
                            CMD_CLEAR: begin
                                r_acc   <= '0;
                                r_last  <= '0;
                                r_first <= 1'b1;
                                r_state <= S_DONE;
                            end
                            CMD_UNUSED: begin
                                r_state <= S_DONE;
                            end
                            CMD_SETPOINT, CMD_ERROR: begin
                                if (step_off) begin
                                    r_dis   <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_err   <= n_err;
                                    r_go    <= 1'b1;
                                    r_state <= S_MDT;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                // integral: accum + error*dt, clamped
                S_MDT: begin
                    if (mdu_stat.done) begin
                        r_acc   <= n_acc;
                        r_diff  <= sat_sub(r_err, r_last);
                        r_go    <= 1'b1;
                        r_state <= r_first ? S_MP : S_DIV;
                    end
                end
                // derivative: change in error over dt
                S_DIV: begin
                    if (mdu_stat.done) begin
                        r_der   <= mdu_res;
                        r_go    <= 1'b1;
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    if (mdu_stat.done) begin
                        r_sum   <= mdu_res;
                        r_go    <= 1'b1;
                        r_state <= S_MI;
                    end
                end
                S_MI: begin
                    if (mdu_stat.done) begin
                        r_sum   <= n_sum;
                        r_go    <= !r_first;
                        r_state <= r_first ? S_CLAMP : S_MD;
                    end
                end
                S_MD: begin
                    if (mdu_stat.done) begin
                        r_sum   <= n_sum;
                        r_state <= S_CLAMP;
                    end
                end
                // output limits and end-of-update state
                S_CLAMP: begin
                    r_sum   <= clamp(r_sum, r_drive_min, r_drive_max);
                    r_last  <= r_err;
                    r_first <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_drive <= r_sum;
                        r_out_dis   <= r_dis;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready      = (r_state == S_IDLE);
    assign o_result.valid    = r_out_valid;
    assign o_result.drive    = r_out_drive;
    assign o_result.disabled = r_out_dis;

    // unit is only started when idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_ctrl.start |-> !mdu_stat.busy)
        else $error("shared unit started while busy");

    // unit completions only land in states that consume them
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_stat.done |-> (r_state == S_MDT || r_state == S_DIV || r_state == S_MP
                           || r_state == S_MI || r_state == S_MD))
        else $error("unit result arrived in a state that ignores it");

    // a clear item empties the controller state
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_item.cmd == CMD_CLEAR) |=> (r_acc == '0 && r_last == '0 && r_first))
        else $error("clear item did not reset the controller state");

    // a skipped update reports zero drive
    a_dis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.disabled) |-> (o_result.drive == '0))
        else $error("disabled result with nonzero drive");

endmodule
